// ===== rtl/dlefp_pkg.sv =====
// ---------------------------------------------------------------------------
// DLE frame receive parser package
// Shared link byte codes, parser phases, state and result types.
// ---------------------------------------------------------------------------
package dlefp_pkg;

    // Link control bytes
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_DLE = 8'h10;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;

    // Header byte counts included in the length field
    localparam logic [15:0] HDR_PLAIN = 16'd4;
    localparam logic [15:0] HDR_LOCK  = 16'd5;

    // Last link reply codes
    localparam logic [1:0] REPLY_ACK = 2'd0;
    localparam logic [1:0] REPLY_DLE = 2'd1;
    localparam logic [1:0] REPLY_NAK = 2'd2;

    // Parser phases, one-hot
    typedef enum logic [11:0] {
        PH_ACKNAK = 12'b0000_0000_0001,
        PH_DLE1   = 12'b0000_0000_0010,
        PH_STX    = 12'b0000_0000_0100,
        PH_LEN1   = 12'b0000_0000_1000,
        PH_LEN2   = 12'b0000_0001_0000,
        PH_CODE1  = 12'b0000_0010_0000,
        PH_CODE2  = 12'b0000_0100_0000,
        PH_LOCK   = 12'b0000_1000_0000,
        PH_DATA   = 12'b0001_0000_0000,
        PH_CRC    = 12'b0010_0000_0000,
        PH_DLE2   = 12'b0100_0000_0000,
        PH_ETX    = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] frame_length;
        logic [15:0] frame_code;
        logic [7:0]  lock_byte;
        logic [15:0] byte_index;
        logic [7:0]  xor_sum;
        logic        ack_seen;
        logic        dle_seen;
    } t_state;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [15:0] payload_count;
        logic [15:0] command_code;
        logic [7:0]  display_lock;
        logic        frame_done;
        logic [7:0]  checksum_residue;
        logic [1:0]  link_reply;
    } t_result;

endpackage

// ===== rtl/dlefp_if.sv =====
// ---------------------------------------------------------------------------
// DLE frame receive parser channels
// Valid/ready channels for received bytes and parser results.
// ---------------------------------------------------------------------------
interface dlefp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dlefp_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] payload_count;
    logic [15:0] command_code;
    logic [7:0]  display_lock;
    logic        frame_done;
    logic [7:0]  checksum_residue;
    logic [1:0]  link_reply;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output payload_count, output command_code, output display_lock,
        output frame_done, output checksum_residue, output link_reply,
        input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input payload_count, input command_code, input display_lock,
        input frame_done, input checksum_residue, input link_reply,
        output ready
    );
endinterface

// ===== rtl/dle_frame_receive_parser_unit.sv =====
// ---------------------------------------------------------------------------
// DLE frame receive parser
// Byte-wise DLE/STX/ETX frame parser with XOR checksum residue.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one received link byte per beat; o_out carries one result
//   beat per input beat: payload byte with its index, payload count, command
//   code, display-lock byte, frame-done flag, checksum residue, last reply.
//   i_cfg_we/i_cfg_wdata write display_lock_mode; write only while idle.
// Output: a byte's result is registered in the cycle that accepts the byte.
// Throughput: one byte per cycle while o_out is not held; the parser state and
//   the result register both update in the accepting cycle, so beats may follow back to back.
// Stall: while o_out is held, the single result register stays full and
//   i_in.ready drops; a byte is taken again in the cycle the result leaves.
// Reset: synchronous, active low; the parser returns to waiting for a
//   reply, all counters and sums clear, display_lock_mode returns to 1,
//   and the result register empties.
// ---------------------------------------------------------------------------
module dle_frame_receive_parser_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    dlefp_in_if.sink          i_in,
    dlefp_out_if.source       o_out
);
    import dlefp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    r_lock_mode;
    logic    w_in_accept;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_accept = i_in.valid && i_in.ready;

    dlefp_step u_step (
        .i_state     (r_state),
        .i_rx_byte   (i_in.rx_byte),
        .i_lock_mode (r_lock_mode),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_lock_mode <= i_cfg_wdata;
        end
    end

    // Advance parser state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_ACKNAK, default: '0};
        end else if (w_in_accept) begin
            r_state <= n_state;
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.payload_valid    = r_out.payload_valid;
    assign o_out.payload_byte     = r_out.payload_byte;
    assign o_out.payload_index    = r_out.payload_index;
    assign o_out.payload_count    = r_out.payload_count;
    assign o_out.command_code     = r_out.command_code;
    assign o_out.display_lock     = r_out.display_lock;
    assign o_out.frame_done       = r_out.frame_done;
    assign o_out.checksum_residue = r_out.checksum_residue;
    assign o_out.link_reply       = r_out.link_reply;

`ifndef NO_ASSERTIONS
    // A payload beat always falls inside the announced payload
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload_valid) |-> (o_out.payload_index < o_out.payload_count))
        else $error("payload index beyond payload count");

    // Frame completion never coincides with a payload byte
    a_done_not_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done) |-> !o_out.payload_valid)
        else $error("frame done on a payload beat");

    // Every accepted byte leaves a result behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_out_valid)
        else $error("accepted byte produced no result");

    // Completion only follows the closing-ETX phase
    a_done_from_etx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && n_out.frame_done) |-> (r_state.phase == PH_ETX))
        else $error("frame done outside the ETX phase");
`endif

endmodule

// ===== rtl/dlefp_step.sv =====
// ---------------------------------------------------------------------------
// DLE frame parser step
// Next parser state and result for one received byte.
// ---------------------------------------------------------------------------
module dlefp_step (
    input  dlefp_pkg::t_state  i_state,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_lock_mode,
    output dlefp_pkg::t_state  o_state,
    output dlefp_pkg::t_result o_result
);
    import dlefp_pkg::*;

    logic [15:0] w_next_index;
    logic [15:0] w_count;
    logic        w_count_shown;

    // Payload count after removing the header bytes; short lengths give zero
    function automatic logic [15:0] f_payload(input logic [15:0] len, input logic [15:0] hdr);
        f_payload = (len >= hdr) ? (len - hdr) : 16'd0;
    endfunction

    assign w_next_index = i_state.byte_index + 16'd1;

    // Advance the parser by one byte
    always_comb begin
        o_state                 = i_state;
        o_result.payload_valid  = 1'b0;
        o_result.payload_byte   = 8'd0;
        o_result.payload_index  = 16'd0;
        o_result.frame_done     = 1'b0;
        w_count                 = 16'd0;
        unique case (i_state.phase)
            PH_ACKNAK: begin
                if (i_rx_byte == BYTE_ACK) begin
                    o_state.dle_seen = 1'b0;
                    o_state.ack_seen = 1'b1;
                    o_state.phase    = PH_DLE1;
                end else if (i_rx_byte == BYTE_NAK) begin
                    o_state.ack_seen = 1'b0;
                    o_state.phase    = PH_DLE1;
                end else if (i_rx_byte == BYTE_DLE) begin
                    o_state.ack_seen = 1'b0;
                    o_state.dle_seen = 1'b1;
                    o_state.phase    = PH_STX;
                end
            end
            PH_DLE1: begin
                o_state.phase = (i_rx_byte == BYTE_DLE) ? PH_STX : PH_ACKNAK;
            end
            PH_STX: begin
                o_state.phase   = (i_rx_byte == BYTE_STX) ? PH_LEN1 : PH_ACKNAK;
                o_state.xor_sum = 8'd0;
            end
            PH_LEN1: begin
                o_state.frame_length = {i_rx_byte, 8'd0};
                o_state.xor_sum      = i_state.xor_sum ^ i_rx_byte;
                o_state.phase        = PH_LEN2;
            end
            PH_LEN2: begin
                o_state.frame_length = {i_state.frame_length[15:8], i_rx_byte};
                o_state.xor_sum      = i_state.xor_sum ^ i_rx_byte;
                o_state.phase        = PH_CODE1;
            end
            PH_CODE1: begin
                o_state.frame_code = {i_rx_byte, 8'd0};
                o_state.xor_sum    = i_state.xor_sum ^ i_rx_byte;
                o_state.phase      = PH_CODE2;
            end
            PH_CODE2: begin
                o_state.frame_code = {i_state.frame_code[15:8], i_rx_byte};
                o_state.xor_sum    = i_state.xor_sum ^ i_rx_byte;
                if (i_lock_mode) begin
                    o_state.phase = PH_LOCK;
                end else begin
                    w_count              = f_payload(i_state.frame_length, HDR_PLAIN);
                    o_state.frame_length = w_count;
                    o_state.byte_index   = 16'd0;
                    o_state.phase        = (w_count == 16'd0) ? PH_CRC : PH_DATA;
                end
            end
            PH_LOCK: begin
                w_count              = f_payload(i_state.frame_length, HDR_LOCK);
                o_state.lock_byte    = i_rx_byte;
                o_state.frame_length = w_count;
                o_state.byte_index   = 16'd0;
                o_state.phase        = (w_count == 16'd0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_rx_byte;
                o_result.payload_index = i_state.byte_index;
                o_state.xor_sum        = i_state.xor_sum ^ i_rx_byte;
                o_state.byte_index     = w_next_index;
                if (w_next_index >= i_state.frame_length) begin
                    o_state.phase = PH_CRC;
                end
            end
            PH_CRC: begin
                o_state.xor_sum = i_state.xor_sum ^ i_rx_byte;
                o_state.phase   = PH_DLE2;
            end
            PH_DLE2: begin
                o_state.phase = (i_rx_byte == BYTE_DLE) ? PH_ETX : PH_ACKNAK;
            end
            PH_ETX: begin
                o_result.frame_done = (i_rx_byte == BYTE_ETX);
                o_state.phase       = PH_ACKNAK;
            end
            default: begin
                o_state.phase = PH_ACKNAK;
            end
        endcase

        // Show the payload count from the end of the header through frame end
        w_count_shown = (o_state.phase == PH_DATA) || (o_state.phase == PH_CRC) ||
                        (o_state.phase == PH_DLE2) || (o_state.phase == PH_ETX) ||
                        o_result.frame_done;

        o_result.payload_count    = w_count_shown ? o_state.frame_length : 16'd0;
        o_result.command_code     = o_state.frame_code;
        o_result.display_lock     = i_lock_mode ? o_state.lock_byte : 8'd0;
        o_result.checksum_residue = o_state.xor_sum;
        o_result.link_reply       = o_state.ack_seen ? REPLY_ACK :
                                    (o_state.dle_seen ? REPLY_DLE : REPLY_NAK);
    end

endmodule

// ===== sim/dle_frame_receive_parser_unit_test.sv =====
// ---------------------------------------------------------------------------
// DLE frame receive parser testbench
// Streams link bytes into the parser through its valid/ready channel and
// checks every result beat against a cycle-free model of the parser kept
// in a small tracker class. A short directed run covers the link replies,
// framing errors, a short length field and a bad ETX. Random frames with
// occasional flaws follow under four idle/stall mixes, with the
// display-lock mode switched between mixes.
// ---------------------------------------------------------------------------
module dle_frame_receive_parser_unit_test;
    import dlefp_pkg::*;

    // Parser model plus the queue of result beats still owed by the block
    class frame_parse_tracker;
        t_phase      phase;
        logic [15:0] frame_length;
        logic [15:0] frame_code;
        logic [15:0] byte_index;
        logic [7:0]  lock_byte;
        logic [7:0]  xor_sum;
        logic        ack_seen;
        logic        dle_seen;
        logic        lock_mode;
        t_result     results_due[$];
        int unsigned fail_count;

        function new();
            phase        = PH_ACKNAK;
            frame_length = '0;
            frame_code   = '0;
            byte_index   = '0;
            lock_byte    = '0;
            xor_sum      = '0;
            ack_seen     = 1'b0;
            dle_seen     = 1'b0;
            lock_mode    = 1'b1;
            fail_count   = 0;
        endfunction

        function void set_lock_mode(logic mode);
            lock_mode = mode;
        endfunction

        // Turn the raw length into a payload count once the header is in
        function void close_header(logic [15:0] hdr_bytes);
            frame_length = (frame_length >= hdr_bytes) ? frame_length - hdr_bytes : 16'd0;
            byte_index   = '0;
            phase        = (frame_length == 16'd0) ? PH_CRC : PH_DATA;
        endfunction

        // Advance the parser by one accepted byte and queue the result it owes
        function void note_rx_byte(logic [7:0] rx);
            t_result want;
            logic    done;
            want = '0;
            done = 1'b0;
            case (phase)
                PH_ACKNAK: begin
                    if (rx == BYTE_ACK) begin
                        dle_seen = 1'b0;
                        ack_seen = 1'b1;
                        phase    = PH_DLE1;
                    end else if (rx == BYTE_NAK) begin
                        ack_seen = 1'b0;
                        phase    = PH_DLE1;
                    end else if (rx == BYTE_DLE) begin
                        ack_seen = 1'b0;
                        dle_seen = 1'b1;
                        phase    = PH_STX;
                    end
                end
                PH_DLE1: phase = (rx == BYTE_DLE) ? PH_STX : PH_ACKNAK;
                PH_STX: begin
                    phase   = (rx == BYTE_STX) ? PH_LEN1 : PH_ACKNAK;
                    xor_sum = '0;
                end
                PH_LEN1: begin
                    frame_length = {rx, 8'h00};
                    xor_sum      = xor_sum ^ rx;
                    phase        = PH_LEN2;
                end
                PH_LEN2: begin
                    frame_length = frame_length | {8'h00, rx};
                    xor_sum      = xor_sum ^ rx;
                    phase        = PH_CODE1;
                end
                PH_CODE1: begin
                    frame_code = {rx, 8'h00};
                    xor_sum    = xor_sum ^ rx;
                    phase      = PH_CODE2;
                end
                PH_CODE2: begin
                    frame_code = frame_code | {8'h00, rx};
                    xor_sum    = xor_sum ^ rx;
                    if (lock_mode) begin
                        phase = PH_LOCK;
                    end else begin
                        close_header(HDR_PLAIN);
                    end
                end
                PH_LOCK: begin
                    lock_byte = rx;
                    close_header(HDR_LOCK);
                end
                PH_DATA: begin
                    want.payload_valid = 1'b1;
                    want.payload_byte  = rx;
                    want.payload_index = byte_index;
                    xor_sum            = xor_sum ^ rx;
                    byte_index         = byte_index + 16'd1;
                    if (byte_index >= frame_length) begin
                        phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    xor_sum = xor_sum ^ rx;
                    phase   = PH_DLE2;
                end
                PH_DLE2: phase = (rx == BYTE_DLE) ? PH_ETX : PH_ACKNAK;
                PH_ETX: begin
                    done  = (rx == BYTE_ETX);
                    phase = PH_ACKNAK;
                end
                default: phase = PH_ACKNAK;
            endcase

            // Payload count is visible from the end of the header to frame close
            if (done || phase == PH_DATA || phase == PH_CRC || phase == PH_DLE2 ||
                    phase == PH_ETX) begin
                want.payload_count = frame_length;
            end
            want.command_code     = frame_code;
            want.display_lock     = lock_mode ? lock_byte : 8'h00;
            want.frame_done       = done;
            want.checksum_residue = xor_sum;
            want.link_reply       = ack_seen ? REPLY_ACK : (dle_seen ? REPLY_DLE : REPLY_NAK);
            results_due.push_back(want);
        endfunction

        function int unsigned due_count();
            return results_due.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                fail_count++;
            end
        endfunction

        // Match one result beat against the oldest owed result
        function void check_result(t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                $error("result beat with no byte outstanding");
                fail_count++;
                return;
            end
            want = results_due.pop_front();
            compare_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
            compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
            compare_field("payload_index", want.payload_index, got.payload_index);
            compare_field("payload_count", want.payload_count, got.payload_count);
            compare_field("command_code", want.command_code, got.command_code);
            compare_field("display_lock", 16'(want.display_lock), 16'(got.display_lock));
            compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
            compare_field("checksum_residue", 16'(want.checksum_residue),
                          16'(got.checksum_residue));
            compare_field("link_reply", 16'(want.link_reply), 16'(got.link_reply));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    dlefp_in_if  in_if ();
    dlefp_out_if out_if ();

    dle_frame_receive_parser_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    frame_parse_tracker tracker;
    int unsigned        src_idle_pct;
    int unsigned        sink_stall_pct;
    int unsigned        sent_total;
    t_result            out_beat;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check each result beat taken, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            out_beat.payload_valid    = out_if.payload_valid;
            out_beat.payload_byte     = out_if.payload_byte;
            out_beat.payload_index    = out_if.payload_index;
            out_beat.payload_count    = out_if.payload_count;
            out_beat.command_code     = out_if.command_code;
            out_beat.display_lock     = out_if.display_lock;
            out_beat.frame_done       = out_if.frame_done;
            out_beat.checksum_residue = out_if.checksum_residue;
            out_beat.link_reply       = out_if.link_reply;
            tracker.check_result(out_beat);
        end
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Offer one byte after a random idle gap and hold it until taken
    task automatic send_byte(input logic [7:0] rx);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= rx;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        tracker.note_rx_byte(rx);
        sent_total++;
    endtask

    task automatic send_sequence(input logic [7:0] seq[$]);
        foreach (seq[k]) begin
            send_byte(seq[k]);
        end
    endtask

    // Drop valid and hold until every owed result has been taken
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (tracker.due_count() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_lock_mode(input logic mode);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        tracker.set_lock_mode(mode);
        i_cfg_we    <= 1'b0;
    endtask

    // Build one frame with random content, now and then with a flaw in it
    task automatic send_random_frame();
        logic [7:0]  seq[$];
        logic [7:0]  cksum;
        logic [7:0]  pay;
        logic [15:0] len_field;
        logic [15:0] code;
        int unsigned hdr;
        int unsigned n_pay;
        int unsigned flaw;
        int unsigned pos;
        int unsigned dle1_pos;
        int unsigned stx_pos;
        hdr       = tracker.lock_mode ? 5 : 4;
        n_pay     = ($urandom_range(7) == 0) ? $urandom_range(40, 12) : $urandom_range(8);
        len_field = 16'(hdr + n_pay);
        flaw      = $urandom_range(23);
        code      = 16'($urandom);
        if (flaw == 0) begin
            // length below the header count: no payload at all
            n_pay     = 0;
            len_field = 16'($urandom_range(hdr - 1));
        end else if (flaw == 1) begin
            len_field = 16'($urandom_range(hdr + 10));
        end else if (flaw == 2) begin
            repeat ($urandom_range(4, 1)) seq.push_back(8'($urandom));
        end

        case ($urandom_range(2))
            0: seq.push_back(BYTE_ACK);
            1: seq.push_back(BYTE_NAK);
            default: ;
        endcase
        dle1_pos = seq.size();
        seq.push_back(BYTE_DLE);
        stx_pos = seq.size();
        seq.push_back(BYTE_STX);
        seq.push_back(len_field[15:8]);
        seq.push_back(len_field[7:0]);
        seq.push_back(code[15:8]);
        seq.push_back(code[7:0]);
        cksum = len_field[15:8] ^ len_field[7:0] ^ code[15:8] ^ code[7:0];
        if (tracker.lock_mode) begin
            seq.push_back(8'($urandom));
        end
        repeat (n_pay) begin
            pay   = 8'($urandom);
            cksum = cksum ^ pay;
            seq.push_back(pay);
        end
        if (flaw == 3) begin
            cksum = cksum ^ 8'($urandom_range(255, 1));
        end
        seq.push_back(cksum);
        seq.push_back(BYTE_DLE);
        seq.push_back(BYTE_ETX);

        case (flaw)
            4: begin
                do pay = 8'($urandom); while (pay == BYTE_ETX);
                seq[seq.size() - 1] = pay;
            end
            5: begin
                do pay = 8'($urandom); while (pay == BYTE_DLE);
                seq[seq.size() - 2] = pay;
            end
            6: begin
                do pay = 8'($urandom); while (pay == BYTE_STX);
                seq[stx_pos] = pay;
            end
            7: begin
                do pay = 8'($urandom); while (pay == BYTE_DLE);
                seq[dle1_pos] = pay;
            end
            8: begin
                pos = $urandom_range(seq.size() - 1, 1);
                while (seq.size() > pos) void'(seq.pop_back());
            end
            9: seq[$urandom_range(seq.size() - 1)] = 8'($urandom);
            default: ;
        endcase
        send_sequence(seq);
    endtask

    initial begin
        logic [7:0]  seq[$];
        int unsigned budget;
        bit          paused;
        tracker        = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        in_if.valid    = 1'b0;
        in_if.rx_byte  = 8'h00;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sent_total     = 0;
        paused         = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset mode: stray bytes, bad DLE, bad STX, then a short-length frame
        seq = '{8'hFF, 8'h00, BYTE_NAK, 8'h00, BYTE_DLE, 8'h07,
                BYTE_ACK, BYTE_DLE, BYTE_STX, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hA5,
                8'h02, BYTE_DLE, BYTE_ETX};
        send_sequence(seq);

        // Plain mode: one payload byte, closed by a bad ETX
        write_lock_mode(1'b0);
        seq = '{BYTE_DLE, BYTE_STX, 8'h00, 8'h05, 8'h80, 8'h01, 8'h5A, 8'hDE,
                BYTE_DLE, 8'h00};
        send_sequence(seq);

        // Random frames under each idle/stall mix, alternating the lock mode
        budget = sent_total;
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            write_lock_mode((mix % 2) == 0);
            budget += 380;
            while (sent_total < budget) begin
                send_random_frame();
                if (mix == 1 && !paused && sent_total + 190 > budget) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.due_count() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop if the handshake ever locks up
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
